>>> design/vp9lf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp9lf_pkg
// Types, constants and helper functions shared by the VP9 segment
// loop filter level block.
// ----------------------------------------------------------------------------
package vp9lf_pkg;

    localparam int LEVEL_W   = 6;
    localparam int DELTA_W   = 7;
    localparam int SEG_W     = 3;
    localparam int FLAGS_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;
    localparam int SUM_W     = 10;   // level + 2 scaled deltas, signed

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 6'd63;

    // mode_flags bit positions
    localparam int FLAG_SEG_EN = 0;
    localparam int FLAG_ABS    = 1;
    localparam int FLAG_DELTA  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE_FLAGS  = 3'd0,
        CFG_BASE_LEVEL  = 3'd1,
        CFG_REF_INTRA   = 3'd2,
        CFG_REF_LAST    = 3'd3,
        CFG_REF_GOLDEN  = 3'd4,
        CFG_REF_ALTREF  = 3'd5,
        CFG_MODE_ZERO   = 3'd6,
        CFG_MODE_ONE    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [FLAGS_W-1:0]        mode_flags;
        logic [LEVEL_W-1:0]        base_level;
        logic signed [DELTA_W-1:0] ref_intra;
        logic signed [DELTA_W-1:0] ref_last;
        logic signed [DELTA_W-1:0] ref_golden;
        logic signed [DELTA_W-1:0] ref_altref;
        logic signed [DELTA_W-1:0] mode_zero;
        logic signed [DELTA_W-1:0] mode_one;
    } t_cfg_regs;

    typedef struct packed {
        logic [SEG_W-1:0]          segment_index;
        logic                      feature_on;
        logic signed [DELTA_W-1:0] feature_value;
    } t_req;

    typedef struct packed {
        logic [SEG_W-1:0]   segment_out;
        logic [LEVEL_W-1:0] level_intra;
        logic [LEVEL_W-1:0] level_last_m0;
        logic [LEVEL_W-1:0] level_last_m1;
        logic [LEVEL_W-1:0] level_golden_m0;
        logic [LEVEL_W-1:0] level_golden_m1;
        logic [LEVEL_W-1:0] level_altref_m0;
        logic [LEVEL_W-1:0] level_altref_m1;
    } t_rsp;

    // saturate a signed sum into 0..63
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [SUM_W-1:0] v);
        logic [LEVEL_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({{(SUM_W-LEVEL_W){1'b0}}, LEVEL_MAX})) begin
            res = LEVEL_MAX;
        end else begin
            res = v[LEVEL_W-1:0];
        end
        return res;
    endfunction

    // delta times scale, scale is 2 when dbl is set, else 1
    function automatic logic signed [SUM_W-1:0] scale_delta(
        input logic signed [DELTA_W-1:0] d,
        input logic                      dbl
    );
        logic signed [SUM_W-1:0] ext;
        ext = {{(SUM_W-DELTA_W){d[DELTA_W-1]}}, d};
        return dbl ? (ext <<< 1) : ext;
    endfunction

endpackage

>>> design/vp9lf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp9lf_if
// Request, response and register write channels of the loop filter
// level block.
// ----------------------------------------------------------------------------
interface vp9lf_req_if;
    logic                                          valid;
    logic                                          ready;
    logic [vp9lf_pkg::SEG_W-1:0]                   segment_index;
    logic                                          feature_on;
    logic signed [vp9lf_pkg::DELTA_W-1:0]          feature_value;

    modport source (output valid, segment_index, feature_on, feature_value, input ready);
    modport sink   (input valid, segment_index, feature_on, feature_value, output ready);
endinterface

interface vp9lf_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [vp9lf_pkg::SEG_W-1:0]       segment_out;
    logic [vp9lf_pkg::LEVEL_W-1:0]     level_intra;
    logic [vp9lf_pkg::LEVEL_W-1:0]     level_last_m0;
    logic [vp9lf_pkg::LEVEL_W-1:0]     level_last_m1;
    logic [vp9lf_pkg::LEVEL_W-1:0]     level_golden_m0;
    logic [vp9lf_pkg::LEVEL_W-1:0]     level_golden_m1;
    logic [vp9lf_pkg::LEVEL_W-1:0]     level_altref_m0;
    logic [vp9lf_pkg::LEVEL_W-1:0]     level_altref_m1;

    modport source (output valid, segment_out, level_intra, level_last_m0, level_last_m1,
                    level_golden_m0, level_golden_m1, level_altref_m0, level_altref_m1,
                    input ready);
    modport sink   (input valid, segment_out, level_intra, level_last_m0, level_last_m1,
                    level_golden_m0, level_golden_m1, level_altref_m0, level_altref_m1,
                    output ready);
endinterface

interface vp9lf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vp9lf_pkg::CFG_IDX_W-1:0]     index;
    logic [vp9lf_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/vp9_segment_loop_filter_levels_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp9_segment_loop_filter_levels_core
// VP9 per-segment loop filter levels: one request of segment feature
// data in, one response of seven clamped filter levels out.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the response side is ready:
// the request is captured in an input register, the level select, delta
// scaling and clamps run in one combinational pass, and the seven levels
// land in the response register. Both registers advance while the response
// side is stalled only as far as there is room, so a waiting response never
// blocks the request that follows it; with the response side ready, the rate
// is one request per cycle, set by the single pass between the two registers.
// Registers are written through the configuration channel, which is always
// ready; write them only while no request is in flight.
// ----------------------------------------------------------------------------
module vp9_segment_loop_filter_levels_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vp9lf_req_if.sink     i_req,
    vp9lf_rsp_if.source   o_rsp,
    vp9lf_cfg_if.sink     i_cfg
);

    // configuration registers
    vp9lf_pkg::t_cfg_regs w_regs;

    vp9lf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (w_regs)
    );

    // input register stage
    logic               r_in_valid;
    vp9lf_pkg::t_req    r_in;
    vp9lf_pkg::t_req    w_req;

    // response register stage
    logic               r_out_valid;
    vp9lf_pkg::t_rsp    r_out;
    vp9lf_pkg::t_rsp    w_calc;

    logic               w_out_load;
    logic               w_in_load;

    assign w_req.segment_index = i_req.segment_index;
    assign w_req.feature_on    = i_req.feature_on;
    assign w_req.feature_value = i_req.feature_value;

    // response register frees when empty or being taken this cycle
    assign w_out_load  = !r_out_valid || o_rsp.ready;
    // input register frees when empty or moving forward
    assign i_req.ready = !r_in_valid || w_out_load;
    assign w_in_load   = i_req.valid && i_req.ready;

    vp9lf_level_calc u_level_calc (
        .i_regs (w_regs),
        .i_req  (r_in),
        .o_rsp  (w_calc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_in <= w_req;
        end
        if (w_out_load && r_in_valid) begin
            r_out <= w_calc;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.segment_out     = r_out.segment_out;
    assign o_rsp.level_intra     = r_out.level_intra;
    assign o_rsp.level_last_m0   = r_out.level_last_m0;
    assign o_rsp.level_last_m1   = r_out.level_last_m1;
    assign o_rsp.level_golden_m0 = r_out.level_golden_m0;
    assign o_rsp.level_golden_m1 = r_out.level_golden_m1;
    assign o_rsp.level_altref_m0 = r_out.level_altref_m0;
    assign o_rsp.level_altref_m1 = r_out.level_altref_m1;

`ifndef SYNTH
    // an accepted request sits in the input register next cycle
    a_req_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_in_valid)
        else $error("accepted request not captured");

    // a request moving forward shows up as a response next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_out_load |=> r_out_valid)
        else $error("request lost between stages");

    // an empty response register never throttles requests
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("request side stalled with free response register");

    // with deltas off all seven levels are the segment level
    a_flat_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_regs.mode_flags[vp9lf_pkg::FLAG_DELTA] |->
            w_calc.level_intra == w_calc.level_last_m0 &&
            w_calc.level_intra == w_calc.level_last_m1 &&
            w_calc.level_intra == w_calc.level_golden_m0 &&
            w_calc.level_intra == w_calc.level_golden_m1 &&
            w_calc.level_intra == w_calc.level_altref_m0 &&
            w_calc.level_intra == w_calc.level_altref_m1)
        else $error("levels differ with deltas disabled");
`endif

endmodule

>>> design/vp9lf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp9lf_cfg_regs
// Register file for mode flags, base level and the six level deltas.
// ----------------------------------------------------------------------------
module vp9lf_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vp9lf_cfg_if.sink             i_cfg,
    output vp9lf_pkg::t_cfg_regs  o_regs
);

    vp9lf_pkg::t_cfg_regs r_regs;
    vp9lf_pkg::t_cfg_regs n_regs;

    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    always_comb begin
        n_regs = r_regs;
        if (i_cfg.valid) begin
            case (vp9lf_pkg::t_cfg_idx'(i_cfg.index))
                vp9lf_pkg::CFG_MODE_FLAGS: begin
                    n_regs.mode_flags = i_cfg.data[vp9lf_pkg::FLAGS_W-1:0];
                end
                vp9lf_pkg::CFG_BASE_LEVEL: begin
                    n_regs.base_level = i_cfg.data[vp9lf_pkg::LEVEL_W-1:0];
                end
                vp9lf_pkg::CFG_REF_INTRA:  n_regs.ref_intra  = i_cfg.data;
                vp9lf_pkg::CFG_REF_LAST:   n_regs.ref_last   = i_cfg.data;
                vp9lf_pkg::CFG_REF_GOLDEN: n_regs.ref_golden = i_cfg.data;
                vp9lf_pkg::CFG_REF_ALTREF: n_regs.ref_altref = i_cfg.data;
                vp9lf_pkg::CFG_MODE_ZERO:  n_regs.mode_zero  = i_cfg.data;
                vp9lf_pkg::CFG_MODE_ONE:   n_regs.mode_one   = i_cfg.data;
                default: n_regs = r_regs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else begin
            r_regs <= n_regs;
        end
    end

endmodule

>>> design/vp9lf_level_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp9lf_level_calc
// Segment level select and clamp, then scaled ref/mode delta sums and
// clamps for the seven filter levels.
// ----------------------------------------------------------------------------
module vp9lf_level_calc (
    input  vp9lf_pkg::t_cfg_regs i_regs,
    input  vp9lf_pkg::t_req      i_req,
    output vp9lf_pkg::t_rsp      o_rsp
);

    localparam int SW = vp9lf_pkg::SUM_W;
    localparam int LW = vp9lf_pkg::LEVEL_W;
    localparam int DW = vp9lf_pkg::DELTA_W;

    logic signed [SW-1:0] w_base;
    logic signed [SW-1:0] w_data;
    logic signed [SW-1:0] w_raw;
    logic                 w_seg_use;
    logic [LW-1:0]        w_level;
    logic signed [SW-1:0] w_lvl;
    logic                 w_dbl;
    logic signed [SW-1:0] w_ri, w_rl, w_rg, w_ra, w_m0, w_m1;

    assign w_base    = {{(SW-LW){1'b0}}, i_regs.base_level};
    assign w_data    = {{(SW-DW){i_req.feature_value[DW-1]}}, i_req.feature_value};
    assign w_seg_use = i_regs.mode_flags[vp9lf_pkg::FLAG_SEG_EN] & i_req.feature_on;
    assign w_raw     = i_regs.mode_flags[vp9lf_pkg::FLAG_ABS] ? w_data : (w_base + w_data);
    assign w_level   = w_seg_use ? vp9lf_pkg::clamp_level(w_raw) : i_regs.base_level;
    assign w_lvl     = {{(SW-LW){1'b0}}, w_level};

    // scale doubles once the level reaches 32
    assign w_dbl = w_level[LW-1];
    assign w_ri  = vp9lf_pkg::scale_delta(i_regs.ref_intra,  w_dbl);
    assign w_rl  = vp9lf_pkg::scale_delta(i_regs.ref_last,   w_dbl);
    assign w_rg  = vp9lf_pkg::scale_delta(i_regs.ref_golden, w_dbl);
    assign w_ra  = vp9lf_pkg::scale_delta(i_regs.ref_altref, w_dbl);
    assign w_m0  = vp9lf_pkg::scale_delta(i_regs.mode_zero,  w_dbl);
    assign w_m1  = vp9lf_pkg::scale_delta(i_regs.mode_one,   w_dbl);

    always_comb begin
        o_rsp.segment_out = i_req.segment_index;
        if (i_regs.mode_flags[vp9lf_pkg::FLAG_DELTA]) begin
            o_rsp.level_intra     = vp9lf_pkg::clamp_level(w_lvl + w_ri);
            o_rsp.level_last_m0   = vp9lf_pkg::clamp_level(w_lvl + w_rl + w_m0);
            o_rsp.level_last_m1   = vp9lf_pkg::clamp_level(w_lvl + w_rl + w_m1);
            o_rsp.level_golden_m0 = vp9lf_pkg::clamp_level(w_lvl + w_rg + w_m0);
            o_rsp.level_golden_m1 = vp9lf_pkg::clamp_level(w_lvl + w_rg + w_m1);
            o_rsp.level_altref_m0 = vp9lf_pkg::clamp_level(w_lvl + w_ra + w_m0);
            o_rsp.level_altref_m1 = vp9lf_pkg::clamp_level(w_lvl + w_ra + w_m1);
        end else begin
            o_rsp.level_intra     = w_level;
            o_rsp.level_last_m0   = w_level;
            o_rsp.level_last_m1   = w_level;
            o_rsp.level_golden_m0 = w_level;
            o_rsp.level_golden_m1 = w_level;
            o_rsp.level_altref_m0 = w_level;
            o_rsp.level_altref_m1 = w_level;
        end
    end

endmodule
